>>> rtl/core/psp_pkg.sv
`timescale 1ns / 1ps

package psp_pkg;

    // Accumulator width; width and precision saturate at 2^COUNT_BITS-1 (8 to 31)
    localparam int COUNT_BITS = 31;
    localparam int FIELD_BITS = 31;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Format characters
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_LC_C  = 8'h63;
    localparam logic [7:0] CH_LC_S  = 8'h73;
    localparam logic [7:0] CH_LC_P  = 8'h70;
    localparam logic [7:0] CH_LC_D  = 8'h64;
    localparam logic [7:0] CH_LC_I  = 8'h69;
    localparam logic [7:0] CH_LC_U  = 8'h75;
    localparam logic [7:0] CH_LC_X  = 8'h78;
    localparam logic [7:0] CH_UC_X  = 8'h58;

    // Parse phase
    typedef enum logic [2:0] {
        PH_FLAGS,
        PH_WIDTH,
        PH_WSTAR,
        PH_PREC,
        PH_PSTAR
    } t_phase;

    // What the current character does in the current phase
    typedef enum logic [2:0] {
        ACT_MINUS,
        ACT_ZERO,
        ACT_WDIG,
        ACT_WSTAR,
        ACT_DOT,
        ACT_PDIG,
        ACT_PSTAR,
        ACT_END
    } t_act;

    // Conversion codes as reported on conv_type
    typedef enum logic [3:0] {
        CONV_C   = 4'd0,
        CONV_S   = 4'd1,
        CONV_P   = 4'd2,
        CONV_D   = 4'd3,
        CONV_I   = 4'd4,
        CONV_U   = 4'd5,
        CONV_LX  = 4'd6,
        CONV_UX  = 4'd7,
        CONV_PCT = 4'd8
    } t_conv;

    typedef struct packed {
        logic  hit;
        t_conv code;
    } t_conv_hit;

    // Conversion letter lookup
    function automatic t_conv_hit conv_lookup(input logic [7:0] ch);
        t_conv_hit r;
        r.hit  = 1'b1;
        r.code = CONV_C;
        unique case (ch)
            CH_LC_C: r.code = CONV_C;
            CH_LC_S: r.code = CONV_S;
            CH_LC_P: r.code = CONV_P;
            CH_LC_D: r.code = CONV_D;
            CH_LC_I: r.code = CONV_I;
            CH_LC_U: r.code = CONV_U;
            CH_LC_X: r.code = CONV_LX;
            CH_UC_X: r.code = CONV_UX;
            CH_PCT:  r.code = CONV_PCT;
            default: r.hit  = 1'b0;
        endcase
        return r;
    endfunction

    // acc * 10 + digit, saturating
    function automatic logic [COUNT_BITS-1:0] acc_digit(
        input logic [COUNT_BITS-1:0] acc,
        input logic [3:0]            dig
    );
        logic [COUNT_BITS+3:0] wide;
        wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{COUNT_BITS{1'b0}}, dig};
        return (wide > {4'b0, COUNT_MAX}) ? COUNT_MAX : wide[COUNT_BITS-1:0];
    endfunction

endpackage

>>> rtl/core/printf_spec_parser.sv
`timescale 1ns / 1ps

// Parses a printf conversion specifier one character per word, starting with the
// character after the percent sign; the star argument travels with every word and
// is used only on a '*'. A word is taken every cycle the result register is free
// or being drained, so the sustained rate is one character per clock. The parse
// state is updated by a single pass of logic (one multiply-by-ten accumulate and a
// saturating compare) and the finished specifier is presented from the result
// register in the cycle after the conversion letter, or the failing character,
// is accepted. On failure ok is 0 and every other field is 0. After each result
// the parser is back in its flag phase, ready for the next specifier.
module printf_spec_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // character channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_ch,
    input  logic [31:0] i_star_value,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_ok,
    output logic        o_left_align,
    output logic        o_zero_pad,
    output logic        o_width_given,
    output logic [30:0] o_field_width,
    output logic        o_prec_given,
    output logic [30:0] o_precision,
    output logic [3:0]  o_conv_type
);

    // Parse state
    psp_pkg::t_phase                  r_phase, n_phase;
    logic                             r_left_flag, n_left_flag;
    logic                             r_zero_flag, n_zero_flag;
    logic                             r_width_set, n_width_set;
    logic [psp_pkg::COUNT_BITS-1:0]   r_width_acc, n_width_acc;
    logic                             r_prec_set, n_prec_set;
    logic [psp_pkg::COUNT_BITS-1:0]   r_prec_acc, n_prec_acc;

    // Result register
    logic                             r_out_valid, n_out_valid;
    logic                             r_ok, n_ok;
    logic                             r_left, n_left;
    logic                             r_zero, n_zero;
    logic                             r_wgiven, n_wgiven;
    logic [30:0]                      r_fwidth, n_fwidth;
    logic                             r_pgiven, n_pgiven;
    logic [30:0]                      r_prec, n_prec;
    logic [3:0]                       r_conv, n_conv;

    logic                             accept;
    logic                             emit;
    logic                             is_digit;
    logic                             star_neg;
    logic [31:0]                      star_abs;
    logic [psp_pkg::COUNT_BITS-1:0]   star_mag;
    psp_pkg::t_act                    act;
    psp_pkg::t_conv_hit               conv;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign emit    = accept && (act == psp_pkg::ACT_END);

    // Character decode and star magnitude
    assign is_digit = (i_ch >= psp_pkg::CH_ZERO) && (i_ch <= psp_pkg::CH_NINE);
    assign star_neg = i_star_value[31];
    assign star_abs = star_neg ? (~i_star_value + 32'd1) : i_star_value;
    assign star_mag = (star_abs > {{(32 - psp_pkg::COUNT_BITS){1'b0}}, psp_pkg::COUNT_MAX})
                    ? psp_pkg::COUNT_MAX : star_abs[psp_pkg::COUNT_BITS-1:0];
    assign conv     = psp_pkg::conv_lookup(i_ch);

    // Classify the character against the current phase
    always_comb begin
        act = psp_pkg::ACT_END;
        unique case (r_phase)
            psp_pkg::PH_FLAGS: begin
                priority if (i_ch == psp_pkg::CH_MINUS) act = psp_pkg::ACT_MINUS;
                else if (i_ch == psp_pkg::CH_ZERO)      act = psp_pkg::ACT_ZERO;
                else if (is_digit)                       act = psp_pkg::ACT_WDIG;
                else if (i_ch == psp_pkg::CH_STAR)       act = psp_pkg::ACT_WSTAR;
                else if (i_ch == psp_pkg::CH_DOT)        act = psp_pkg::ACT_DOT;
                else                                     act = psp_pkg::ACT_END;
            end
            psp_pkg::PH_WIDTH: begin
                priority if (is_digit)              act = psp_pkg::ACT_WDIG;
                else if (i_ch == psp_pkg::CH_DOT)   act = psp_pkg::ACT_DOT;
                else                                act = psp_pkg::ACT_END;
            end
            psp_pkg::PH_WSTAR: begin
                act = (i_ch == psp_pkg::CH_DOT) ? psp_pkg::ACT_DOT : psp_pkg::ACT_END;
            end
            psp_pkg::PH_PREC: begin
                priority if (is_digit)              act = psp_pkg::ACT_PDIG;
                else if (i_ch == psp_pkg::CH_STAR)  act = psp_pkg::ACT_PSTAR;
                else                                act = psp_pkg::ACT_END;
            end
            default: act = psp_pkg::ACT_END;
        endcase
    end

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            unique case (act)
                psp_pkg::ACT_MINUS,
                psp_pkg::ACT_ZERO:  n_phase = psp_pkg::PH_FLAGS;
                psp_pkg::ACT_WDIG:  n_phase = psp_pkg::PH_WIDTH;
                psp_pkg::ACT_WSTAR: n_phase = psp_pkg::PH_WSTAR;
                psp_pkg::ACT_DOT,
                psp_pkg::ACT_PDIG:  n_phase = psp_pkg::PH_PREC;
                psp_pkg::ACT_PSTAR: n_phase = psp_pkg::PH_PSTAR;
                psp_pkg::ACT_END:   n_phase = psp_pkg::PH_FLAGS;
                default:            n_phase = psp_pkg::PH_FLAGS;
            endcase
        end
    end

    // Flag and accumulator updates, result formation
    always_comb begin
        n_left_flag = r_left_flag;
        n_zero_flag = r_zero_flag;
        n_width_set = r_width_set;
        n_width_acc = r_width_acc;
        n_prec_set  = r_prec_set;
        n_prec_acc  = r_prec_acc;
        n_ok        = r_ok;
        n_left      = r_left;
        n_zero      = r_zero;
        n_wgiven    = r_wgiven;
        n_fwidth    = r_fwidth;
        n_pgiven    = r_pgiven;
        n_prec      = r_prec;
        n_conv      = r_conv;

        if (accept) begin
            unique case (act)
                psp_pkg::ACT_MINUS: n_left_flag = 1'b1;
                psp_pkg::ACT_ZERO:  n_zero_flag = 1'b1;
                psp_pkg::ACT_WDIG: begin
                    n_width_set = 1'b1;
                    n_width_acc = psp_pkg::acc_digit(r_width_acc, i_ch[3:0]);
                end
                psp_pkg::ACT_WSTAR: begin
                    // negative width means left align, zero pad dropped
                    n_width_set = 1'b1;
                    n_width_acc = star_mag;
                    if (star_neg) begin
                        n_left_flag = 1'b1;
                        n_zero_flag = 1'b0;
                    end
                end
                psp_pkg::ACT_DOT: begin
                    n_prec_set = 1'b1;
                    n_prec_acc = '0;
                end
                psp_pkg::ACT_PDIG: begin
                    n_prec_acc = psp_pkg::acc_digit(r_prec_acc, i_ch[3:0]);
                end
                psp_pkg::ACT_PSTAR: begin
                    // star overrides digits; negative leaves precision unset
                    n_prec_set = !star_neg;
                    n_prec_acc = star_neg ? '0 : star_mag;
                end
                psp_pkg::ACT_END: begin
                    n_ok     = conv.hit;
                    n_left   = conv.hit && r_left_flag;
                    n_zero   = conv.hit && r_zero_flag;
                    n_wgiven = conv.hit && r_width_set;
                    n_fwidth = conv.hit ? psp_pkg::FIELD_BITS'(r_width_acc) : '0;
                    n_pgiven = conv.hit && r_prec_set;
                    n_prec   = conv.hit ? psp_pkg::FIELD_BITS'(r_prec_acc) : '0;
                    n_conv   = conv.hit ? conv.code : '0;
                    n_left_flag = 1'b0;
                    n_zero_flag = 1'b0;
                    n_width_set = 1'b0;
                    n_width_acc = '0;
                    n_prec_set  = 1'b0;
                    n_prec_acc  = '0;
                end
                default: ;
            endcase
        end
    end

    // Result valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= psp_pkg::PH_FLAGS;
            r_left_flag <= 1'b0;
            r_zero_flag <= 1'b0;
            r_width_set <= 1'b0;
            r_width_acc <= '0;
            r_prec_set  <= 1'b0;
            r_prec_acc  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_left_flag <= n_left_flag;
            r_zero_flag <= n_zero_flag;
            r_width_set <= n_width_set;
            r_width_acc <= n_width_acc;
            r_prec_set  <= n_prec_set;
            r_prec_acc  <= n_prec_acc;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_ok     <= n_ok;
        r_left   <= n_left;
        r_zero   <= n_zero;
        r_wgiven <= n_wgiven;
        r_fwidth <= n_fwidth;
        r_pgiven <= n_pgiven;
        r_prec   <= n_prec;
        r_conv   <= n_conv;
    end

    assign o_valid       = r_out_valid;
    assign o_ok          = r_ok;
    assign o_left_align  = r_left;
    assign o_zero_pad    = r_zero;
    assign o_width_given = r_wgiven;
    assign o_field_width = r_fwidth;
    assign o_prec_given  = r_pgiven;
    assign o_precision   = r_prec;
    assign o_conv_type   = r_conv;

    // A finished specifier leaves the parser clean
    a_clean_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_phase == psp_pkg::PH_FLAGS) && !r_left_flag && !r_zero_flag
                 && !r_width_set && !r_prec_set && (r_width_acc == '0))
        else $error("parse state not cleared after result");

    // A failed specifier carries nothing but ok = 0
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> !o_left_align && !o_zero_pad && !o_width_given
                               && !o_prec_given && (o_field_width == '0)
                               && (o_precision == '0) && (o_conv_type == '0))
        else $error("failure result with non-zero fields");

    // No width or precision can be set while still reading flags
    a_flags_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == psp_pkg::PH_FLAGS) |-> !r_width_set && !r_prec_set
                                           && (r_width_acc == '0) && (r_prec_acc == '0))
        else $error("width or precision set in flag phase");

    // An unset precision holds no value
    a_prec_unset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_prec_set |-> (r_prec_acc == '0))
        else $error("precision value without precision set");

    // Result register loads only on a result, never over an untaken one
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !emit)
        else $error("result overwritten before it was taken");

endmodule

>>> dv/psp_checker.sv
`timescale 1ns / 1ps

// Watches the character and result channels of the spec parser, keeps its own
// model of the parse and compares every finished specifier with the prediction.
module psp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // character channel
    input  logic        i_ch_valid,
    input  logic        i_ch_ready,
    input  logic [7:0]  i_ch,
    input  logic [31:0] i_star_value,
    // result channel
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic        i_ok,
    input  logic        i_left_align,
    input  logic        i_zero_pad,
    input  logic        i_width_given,
    input  logic [30:0] i_field_width,
    input  logic        i_prec_given,
    input  logic [30:0] i_precision,
    input  logic [3:0]  i_conv_type,
    // to the top
    output int          o_fails,
    output int          o_pending
);
    import psp_pkg::*;

    typedef struct packed {
        logic                  ok;
        logic                  left_align;
        logic                  zero_pad;
        logic                  width_given;
        logic [FIELD_BITS-1:0] field_width;
        logic                  prec_given;
        logic [FIELD_BITS-1:0] precision;
        t_conv                 conv_type;
    } t_spec;

    // model of the parse in progress
    t_phase                parse_phase;
    logic                  minus_seen;
    logic                  zero_seen;
    logic                  width_seen;
    logic [COUNT_BITS-1:0] width_count;
    logic                  prec_seen;
    logic [COUNT_BITS-1:0] prec_count;

    // specifiers predicted but not yet handed out, oldest first
    t_spec spec_q[$];

    task automatic report(input string msg);
        $display("[%0t] MISMATCH %s", $realtime, msg);
        o_fails++;
    endtask

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // acc * 10 + digit, clamped at the counter maximum
    function automatic logic [COUNT_BITS-1:0] next_count(
        input logic [COUNT_BITS-1:0] acc,
        input logic [7:0]            c
    );
        longint unsigned v;
        v = 64'(acc) * 10 + 64'(c - CH_ZERO);
        return (v > 64'(COUNT_MAX)) ? COUNT_MAX : v[COUNT_BITS-1:0];
    endfunction

    // returns 1 and the code when c is a conversion letter
    function automatic logic conv_of(input logic [7:0] c, output t_conv code);
        conv_of = 1'b1;
        code    = CONV_C;
        case (c)
            CH_LC_C: code = CONV_C;
            CH_LC_S: code = CONV_S;
            CH_LC_P: code = CONV_P;
            CH_LC_D: code = CONV_D;
            CH_LC_I: code = CONV_I;
            CH_LC_U: code = CONV_U;
            CH_LC_X: code = CONV_LX;
            CH_UC_X: code = CONV_UX;
            CH_PCT:  code = CONV_PCT;
            default: conv_of = 1'b0;
        endcase
    endfunction

    task automatic clear_parse();
        parse_phase = PH_FLAGS;
        minus_seen  = 1'b0;
        zero_seen   = 1'b0;
        width_seen  = 1'b0;
        width_count = '0;
        prec_seen   = 1'b0;
        prec_count  = '0;
    endtask

    // one character word into the model; a finished specifier is queued
    task automatic parse_char(input logic [7:0] c, input logic [31:0] arg);
        logic                  neg;
        longint unsigned       mag;
        logic                  taken;
        logic                  hit;
        t_conv                 code;
        t_spec                 res;
        neg   = arg[31];
        mag   = neg ? (64'd4294967296 - 64'(arg)) : 64'(arg);
        if (mag > 64'(COUNT_MAX))
            mag = 64'(COUNT_MAX);
        taken = 1'b0;

        case (parse_phase)
            PH_FLAGS: begin
                if (c == CH_MINUS) begin
                    minus_seen = 1'b1;
                    taken = 1'b1;
                end else if (c == CH_ZERO) begin
                    zero_seen = 1'b1;
                    taken = 1'b1;
                end else if (is_digit(c)) begin
                    width_seen  = 1'b1;
                    width_count = next_count('0, c);
                    parse_phase = PH_WIDTH;
                    taken = 1'b1;
                end else if (c == CH_STAR) begin
                    // negative star width: left align, no zero pad, magnitude
                    width_seen  = 1'b1;
                    width_count = mag[COUNT_BITS-1:0];
                    if (neg) begin
                        minus_seen = 1'b1;
                        zero_seen  = 1'b0;
                    end
                    parse_phase = PH_WSTAR;
                    taken = 1'b1;
                end
            end
            PH_WIDTH: begin
                if (is_digit(c)) begin
                    width_count = next_count(width_count, c);
                    taken = 1'b1;
                end
            end
            PH_PREC: begin
                if (is_digit(c)) begin
                    prec_count = next_count(prec_count, c);
                    taken = 1'b1;
                end else if (c == CH_STAR) begin
                    // star overrides any digits; negative leaves it unset
                    prec_seen  = !neg;
                    prec_count = neg ? '0 : mag[COUNT_BITS-1:0];
                    parse_phase = PH_PSTAR;
                    taken = 1'b1;
                end
            end
            default: ;
        endcase

        if (!taken && c == CH_DOT &&
            (parse_phase == PH_FLAGS || parse_phase == PH_WIDTH ||
             parse_phase == PH_WSTAR)) begin
            prec_seen   = 1'b1;
            prec_count  = '0;
            parse_phase = PH_PREC;
            taken = 1'b1;
        end

        // anything else ends the specifier, well or badly
        if (!taken) begin
            res = '0;
            hit = conv_of(c, code);
            if (hit) begin
                res.ok          = 1'b1;
                res.left_align  = minus_seen;
                res.zero_pad    = zero_seen;
                res.width_given = width_seen;
                res.field_width = FIELD_BITS'(width_count);
                res.prec_given  = prec_seen;
                res.precision   = FIELD_BITS'(prec_count);
                res.conv_type   = code;
            end
            spec_q.push_back(res);
            clear_parse();
        end
    endtask

    task automatic check_field(
        input string           name,
        input longint unsigned want_v,
        input longint unsigned got_v
    );
        if (want_v !== got_v)
            report($sformatf("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v));
    endtask

    task automatic check_result();
        t_spec want;
        if (spec_q.size() == 0) begin
            report("result word with no specifier pending");
        end else begin
            want = spec_q.pop_front();
            check_field("ok",          want.ok,          i_ok);
            check_field("left_align",  want.left_align,  i_left_align);
            check_field("zero_pad",    want.zero_pad,    i_zero_pad);
            check_field("width_given", want.width_given, i_width_given);
            check_field("field_width", want.field_width, i_field_width);
            check_field("prec_given",  want.prec_given,  i_prec_given);
            check_field("precision",   want.precision,   i_precision);
            check_field("conv_type",   want.conv_type,   i_conv_type);
        end
    endtask

    // results are checked before the same edge's character is modelled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse();
            spec_q.delete();
            o_fails = 0;
            o_pending <= 0;
        end else begin
            if (i_res_valid === 1'b1 && i_res_ready === 1'b1)
                check_result();
            if (i_ch_valid === 1'b1 && i_ch_ready === 1'b1)
                parse_char(i_ch, i_star_value);
            o_pending <= spec_q.size();
        end
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

// Drives character words into the spec parser and drains its results with
// random gaps and stalls; the checker beside the block does the comparing.
module testbench;
    import psp_pkg::*;

    localparam int RANDOM_CHARS = 1200;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        ch_valid   = 1'b0;
    logic        ch_ready;
    logic [7:0]  ch         = '0;
    logic [31:0] star_value = '0;
    logic        res_valid;
    logic        res_ready  = 1'b0;
    logic        res_ok;
    logic        res_left_align;
    logic        res_zero_pad;
    logic        res_width_given;
    logic [30:0] res_field_width;
    logic        res_prec_given;
    logic [30:0] res_precision;
    logic [3:0]  res_conv_type;
    int          fails;
    int          pending;

    int          sent       = 0;
    bit          send_burst = 1'b0;
    bit          recv_burst = 1'b0;

    logic [7:0]  conv_chars [9] = '{CH_LC_C, CH_LC_S, CH_LC_P, CH_LC_D, CH_LC_I,
                                    CH_LC_U, CH_LC_X, CH_UC_X, CH_PCT};

    always #4 clk = ~clk;

    printf_spec_parser dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (ch_valid),
        .o_ready       (ch_ready),
        .i_ch          (ch),
        .i_star_value  (star_value),
        .o_valid       (res_valid),
        .i_ready       (res_ready),
        .o_ok          (res_ok),
        .o_left_align  (res_left_align),
        .o_zero_pad    (res_zero_pad),
        .o_width_given (res_width_given),
        .o_field_width (res_field_width),
        .o_prec_given  (res_prec_given),
        .o_precision   (res_precision),
        .o_conv_type   (res_conv_type)
    );

    psp_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_ch_valid    (ch_valid),
        .i_ch_ready    (ch_ready),
        .i_ch          (ch),
        .i_star_value  (star_value),
        .i_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .i_ok          (res_ok),
        .i_left_align  (res_left_align),
        .i_zero_pad    (res_zero_pad),
        .i_width_given (res_width_given),
        .i_field_width (res_field_width),
        .i_prec_given  (res_prec_given),
        .i_precision   (res_precision),
        .i_conv_type   (res_conv_type),
        .o_fails       (fails),
        .o_pending     (pending)
    );

    // random idle wait, with occasional stretches of none at all
    function automatic int draw_wait(inout bit burst);
        if ($urandom_range(0, 39) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, 8);
    endfunction

    // star argument: small signed, extremes or anything
    function automatic logic [31:0] rand_arg();
        case ($urandom_range(0, 5))
            0, 1: return 32'($urandom_range(0, 40)) - 32'd20;
            2:    return 32'h8000_0000;
            3:    return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // one character word; valid stays up across back-to-back words
    task automatic put_char(input logic [7:0] c, input logic [31:0] arg);
        int gap;
        gap = draw_wait(send_burst);
        if (gap > 0) begin
            ch_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ch_valid   <= 1'b1;
        ch         <= c;
        star_value <= arg;
        do @(posedge clk); while (ch_ready !== 1'b1);
        sent++;
    endtask

    task automatic put_str(input string s, input logic [31:0] arg);
        for (int k = 0; k < s.len(); k++)
            put_char(s[k], arg);
    endtask

    // decimal run; mostly short, now and then long enough to saturate
    task automatic put_digits(input int min_n, input bit lead_nonzero);
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 12) : $urandom_range(min_n, 3);
        for (int k = 0; k < n; k++) begin
            if (k == 0 && lead_nonzero)
                put_char(CH_ZERO + 8'($urandom_range(1, 9)), rand_arg());
            else
                put_char(CH_ZERO + 8'($urandom_range(0, 9)), rand_arg());
        end
    endtask

    // well-formed specifier with random content
    task automatic put_spec();
        repeat ($urandom_range(0, 3))
            put_char($urandom_range(0, 1) ? CH_MINUS : CH_ZERO, rand_arg());
        case ($urandom_range(0, 3))
            0: ;
            1, 2: put_digits(1, 1'b1);
            default: put_char(CH_STAR, rand_arg());
        endcase
        case ($urandom_range(0, 4))
            0, 1: ;
            2: begin
                put_char(CH_DOT, rand_arg());
                put_digits(0, 1'b0);
            end
            3: begin
                put_char(CH_DOT, rand_arg());
                put_char(CH_STAR, rand_arg());
            end
            default: begin
                put_char(CH_DOT, rand_arg());
                put_digits(1, 1'b0);
                put_char(CH_STAR, rand_arg());
            end
        endcase
        put_char(conv_chars[$urandom_range(0, 8)], rand_arg());
    endtask

    // short burst of parser-relevant characters and junk
    task automatic put_noise();
        logic [7:0] c;
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 5))
                0: c = 8'($urandom_range(0, 255));
                1: c = 8'h00;
                2: c = CH_ZERO + 8'($urandom_range(0, 9));
                3: c = conv_chars[$urandom_range(0, 8)];
                4: c = $urandom_range(0, 1) ? CH_STAR : CH_DOT;
                default: c = CH_MINUS;
            endcase
            put_char(c, rand_arg());
        end
    endtask

    // result side: stall drawn per word
    initial begin
        int stall;
        forever begin
            stall = draw_wait(recv_burst);
            if (stall > 0) begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (res_valid !== 1'b1);
        end
    end

    // stimulus and verdict
    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // some conversion letters on their own
        put_str("cpiuX", 32'd0);
        // negative width star at its most negative, after both flags
        put_str("-0*%", 32'h8000_0000);
        // width digits saturating
        put_str("9999999999d", 32'h7FFF_FFFF);
        // star after width digits
        put_str("5*", 32'd0);
        // digit after width star
        put_str("*0", 32'h7FFF_FFFF);
        // flag after width digits
        put_str("1-", 32'd0);
        // lone dot gives precision zero
        put_str(".s", 32'd0);
        // negative precision star after precision digits
        put_str("7.8*x", 32'hFFFF_FFFF);
        // end of string, and the top character code
        put_char(8'h00, 32'd0);
        put_char(8'hFF, 32'hFFFF_FFFF);

        sent = 0;
        while (sent < RANDOM_CHARS) begin
            if ($urandom_range(0, 3) != 0)
                put_spec();
            else
                put_noise();
        end
        ch_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        if (fails == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
